// File: hdl/vpa_pkg.sv
package vpa_pkg;

   localparam int COORD_BITS   = 16;
   localparam int ANGLE_BITS   = 16;
   localparam int CORDIC_STEPS = 30;
   localparam int TURN_BITS    = 32;

   localparam int PROD_BITS  = 2 * COORD_BITS;
   localparam int MAG_BITS   = 2 * COORD_BITS;
   localparam int NORM_BITS  = 30;
   localparam int NORM_TOP   = NORM_BITS - 1;
   localparam int WIDE_BITS  = (MAG_BITS > NORM_BITS) ? MAG_BITS : NORM_BITS;
   localparam int SH_BITS    = $clog2(WIDE_BITS);
   localparam int XY_BITS    = NORM_BITS + 3;

   localparam logic [TURN_BITS-1:0] HALF_TURN = TURN_BITS'(64'h8000_0000);
   localparam logic [TURN_BITS-1:0] ROUND_ADD =
      TURN_BITS'(64'd1) << (TURN_BITS - 1 - ANGLE_BITS);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] a_x;
      logic signed [COORD_BITS-1:0] a_y;
      logic signed [COORD_BITS-1:0] b_x;
      logic signed [COORD_BITS-1:0] b_y;
   } req_type;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] angle;
      logic                  degenerate;
   } rsp_type;

   typedef struct packed {
      logic half_mode;
      logic degenerate;
      logic dot_neg;
      logic cross_neg;
   } meta_type;

   function automatic logic [TURN_BITS-1:0] atan_turn(input int step);
      logic [TURN_BITS-1:0] v;
      case (step)
         0:       v = 32'd536870912;
         1:       v = 32'd316933406;
         2:       v = 32'd167458907;
         3:       v = 32'd85004756;
         4:       v = 32'd42667331;
         5:       v = 32'd21354465;
         6:       v = 32'd10679838;
         7:       v = 32'd5340245;
         8:       v = 32'd2670163;
         9:       v = 32'd1335087;
         10:      v = 32'd667544;
         11:      v = 32'd333772;
         12:      v = 32'd166886;
         13:      v = 32'd83443;
         14:      v = 32'd41722;
         15:      v = 32'd20861;
         16:      v = 32'd10430;
         17:      v = 32'd5215;
         18:      v = 32'd2608;
         19:      v = 32'd1304;
         20:      v = 32'd652;
         21:      v = 32'd326;
         22:      v = 32'd163;
         23:      v = 32'd81;
         24:      v = 32'd41;
         25:      v = 32'd20;
         26:      v = 32'd10;
         27:      v = 32'd5;
         28:      v = 32'd3;
         29:      v = 32'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// File: hdl/vpa_cordic.sv
module vpa_cordic (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  logic signed [vpa_pkg::XY_BITS-1:0]   in_x,
   input  logic signed [vpa_pkg::XY_BITS-1:0]   in_y,
   input  vpa_pkg::meta_type                    in_meta,
   output logic                                 out_valid,
   output logic [vpa_pkg::TURN_BITS-1:0]        out_z,
   output vpa_pkg::meta_type                    out_meta
);

   localparam int N = vpa_pkg::CORDIC_STEPS;

   logic                                src_valid [N+1];
   logic signed [vpa_pkg::XY_BITS-1:0]  src_x     [N+1];
   logic signed [vpa_pkg::XY_BITS-1:0]  src_y     [N+1];
   logic [vpa_pkg::TURN_BITS-1:0]       src_z     [N+1];
   vpa_pkg::meta_type                   src_meta  [N+1];

   logic                                valid_ff  [N];
   logic signed [vpa_pkg::XY_BITS-1:0]  x_ff      [N];
   logic signed [vpa_pkg::XY_BITS-1:0]  y_ff      [N];
   logic [vpa_pkg::TURN_BITS-1:0]       z_ff      [N];
   vpa_pkg::meta_type                   meta_ff   [N];

   logic signed [vpa_pkg::XY_BITS-1:0]  x_in      [N];
   logic signed [vpa_pkg::XY_BITS-1:0]  y_in      [N];
   logic [vpa_pkg::TURN_BITS-1:0]       z_in      [N];

   // arithmetic shift that rounds toward zero
   function automatic logic signed [vpa_pkg::XY_BITS-1:0] shr_tz(
      input logic signed [vpa_pkg::XY_BITS-1:0] v,
      input int                                  s
   );
      logic signed [vpa_pkg::XY_BITS-1:0] r;
      if (v[vpa_pkg::XY_BITS-1]) begin
         r = -((-v) >>> s);
      end else begin
         r = v >>> s;
      end
      return r;
   endfunction

   assign src_valid[0] = in_valid;
   assign src_x[0]     = in_x;
   assign src_y[0]     = in_y;
   assign src_z[0]     = '0;
   assign src_meta[0]  = in_meta;

   for (genvar k = 0; k < N; k++) begin : g_step
      logic signed [vpa_pkg::XY_BITS-1:0] xs;
      logic signed [vpa_pkg::XY_BITS-1:0] ys;
      logic                               y_pos;

      always_comb begin
         xs    = shr_tz(src_x[k], k);
         ys    = shr_tz(src_y[k], k);
         y_pos = !src_y[k][vpa_pkg::XY_BITS-1] && (src_y[k] != '0);
         if (y_pos) begin
            x_in[k] = src_x[k] + ys;
            y_in[k] = src_y[k] - xs;
            z_in[k] = src_z[k] + vpa_pkg::atan_turn(k);
         end else begin
            x_in[k] = src_x[k] - ys;
            y_in[k] = src_y[k] + xs;
            z_in[k] = src_z[k] - vpa_pkg::atan_turn(k);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= src_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[k]    <= x_in[k];
            y_ff[k]    <= y_in[k];
            z_ff[k]    <= z_in[k];
            meta_ff[k] <= src_meta[k];
         end
      end

      assign src_valid[k+1] = valid_ff[k];
      assign src_x[k+1]     = x_ff[k];
      assign src_y[k+1]     = y_ff[k];
      assign src_z[k+1]     = z_ff[k];
      assign src_meta[k+1]  = meta_ff[k];
   end

   assign out_valid = src_valid[N];
   assign out_z     = src_z[N];
   assign out_meta  = src_meta[N];

endmodule

// File: hdl/vector_pair_angle.sv
// vector_pair_angle: angle from vector A to vector B as a fraction of a turn.
// Input channel req_*: req_valid/req_stall carry one req_type (a_x, a_y,
// b_x, b_y). A transfer happens at a clock edge with req_valid high and
// req_stall low. Result channel rsp_*: rsp_valid/rsp_stall carry one
// rsp_type (angle, degenerate), one result per input transfer, in order.
// Config port csr_*: csr_valid/csr_ready write half_circle_mode from
// csr_data; csr_ready is always high. Write it only while the block is idle.
// Path: an input transfer reaches rsp_valid through these stages (four
// multipliers, cross/dot adder, magnitude, leading-one search, normalizing
// shift, 30 CORDIC micro-rotation stages, quadrant fix into the output reg).
// Throughput: one pair per cycle while not frozen; one stage per micro-rotation.
// Stall: a two-entry output (register plus skid) absorbs one more result;
// once the skid register holds a result the whole pipeline freezes and
// req_stall is high until the skid empties. Nothing is dropped or repeated.
// Reset: synchronous, active high; empties the pipeline and clears
// half_circle_mode to full-turn mode.
module vector_pair_angle (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vpa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vpa_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);

   localparam int PB = vpa_pkg::PROD_BITS;
   localparam int MB = vpa_pkg::MAG_BITS;
   localparam int WB = vpa_pkg::WIDE_BITS;
   localparam int SB = vpa_pkg::SH_BITS;
   localparam int XB = vpa_pkg::XY_BITS;
   localparam int TB = vpa_pkg::TURN_BITS;
   localparam int AB = vpa_pkg::ANGLE_BITS;

   logic mode_ff, mode_in;
   logic advance;

   // stage 1: products
   logic                 v1_ff;
   logic signed [PB-1:0] axby_ff, aybx_ff, axbx_ff, ayby_ff;
   logic signed [PB-1:0] axby_in, aybx_in, axbx_in, ayby_in;
   vpa_pkg::meta_type    m1_ff, m1_in;

   // stage 2: cross and dot
   logic               v2_ff;
   logic signed [PB:0] cross_ff, dot_ff, cross_in, dot_in;
   vpa_pkg::meta_type  m2_ff;

   // stage 3: magnitudes
   logic              v3_ff;
   logic [PB:0]       dot_abs, cross_abs;
   logic [MB-1:0]     ux3_ff, uy3_ff, ux3_in, uy3_in;
   vpa_pkg::meta_type m3_ff, m3_in;

   // stage 4: leading one
   logic              v4_ff;
   logic [MB-1:0]     ux4_ff, uy4_ff, mx4;
   logic [SB-1:0]     pos4_ff, pos4_in;
   vpa_pkg::meta_type m4_ff;

   // stage 5: normalized
   logic                 v5_ff;
   logic [WB-1:0]        wx, wy, sx, sy;
   logic signed [XB-1:0] x5_ff, y5_ff, x5_in, y5_in;
   vpa_pkg::meta_type    m5_ff;

   // cordic output
   logic              cv;
   logic [TB-1:0]     cz;
   vpa_pkg::meta_type cm;

   // output register and skid
   logic             rsp_valid_ff, rsp_valid_in;
   vpa_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             skid_valid_ff, skid_valid_in;
   vpa_pkg::rsp_type skid_data_ff, skid_data_in;
   logic [TB-1:0]    full, full_rnd;
   vpa_pkg::rsp_type pipe_rsp;

   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign mode_in = (csr_valid && csr_ready) ? csr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      axby_in = req_data.a_x * req_data.b_y;
      aybx_in = req_data.a_y * req_data.b_x;
      axbx_in = req_data.a_x * req_data.b_x;
      ayby_in = req_data.a_y * req_data.b_y;
      m1_in.half_mode  = mode_ff;
      m1_in.degenerate = ((req_data.a_x == '0) && (req_data.a_y == '0)) ||
                         ((req_data.b_x == '0) && (req_data.b_y == '0));
      m1_in.dot_neg    = 1'b0;
      m1_in.cross_neg  = 1'b0;
   end

   always_comb begin
      cross_in = $signed({axby_ff[PB-1], axby_ff}) - $signed({aybx_ff[PB-1], aybx_ff});
      dot_in   = $signed({axbx_ff[PB-1], axbx_ff}) + $signed({ayby_ff[PB-1], ayby_ff});
   end

   always_comb begin
      dot_abs   = dot_ff[PB]   ? (~dot_ff + 1'b1)   : dot_ff;
      cross_abs = cross_ff[PB] ? (~cross_ff + 1'b1) : cross_ff;
      ux3_in    = dot_abs[MB-1:0];
      uy3_in    = cross_abs[MB-1:0];
      m3_in           = m2_ff;
      m3_in.dot_neg   = dot_ff[PB];
      m3_in.cross_neg = cross_ff[PB];
   end

   always_comb begin
      mx4     = (ux3_ff > uy3_ff) ? ux3_ff : uy3_ff;
      pos4_in = '0;
      for (int i = 0; i < MB; i++) begin
         if (mx4[i]) begin
            pos4_in = SB'(i);
         end
      end
   end

   always_comb begin
      wx = WB'(ux4_ff);
      wy = WB'(uy4_ff);
      if (pos4_ff > SB'(vpa_pkg::NORM_TOP)) begin
         sx = wx >> (pos4_ff - SB'(vpa_pkg::NORM_TOP));
         sy = wy >> (pos4_ff - SB'(vpa_pkg::NORM_TOP));
      end else begin
         sx = wx << (SB'(vpa_pkg::NORM_TOP) - pos4_ff);
         sy = wy << (SB'(vpa_pkg::NORM_TOP) - pos4_ff);
      end
      x5_in = $signed(XB'(sx[vpa_pkg::NORM_TOP:0]));
      y5_in = $signed(XB'(sy[vpa_pkg::NORM_TOP:0]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         axby_ff  <= axby_in;
         aybx_ff  <= aybx_in;
         axbx_ff  <= axbx_in;
         ayby_ff  <= ayby_in;
         m1_ff    <= m1_in;
         cross_ff <= cross_in;
         dot_ff   <= dot_in;
         m2_ff    <= m1_ff;
         ux3_ff   <= ux3_in;
         uy3_ff   <= uy3_in;
         m3_ff    <= m3_in;
         ux4_ff   <= ux3_ff;
         uy4_ff   <= uy3_ff;
         pos4_ff  <= pos4_in;
         m4_ff    <= m3_ff;
         x5_ff    <= x5_in;
         y5_ff    <= y5_in;
         m5_ff    <= m4_ff;
      end
   end

   vpa_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v5_ff),
      .in_x      (x5_ff),
      .in_y      (y5_ff),
      .in_meta   (m5_ff),
      .out_valid (cv),
      .out_z     (cz),
      .out_meta  (cm)
   );

   // quadrant fix and rounding
   always_comb begin
      if (cm.half_mode) begin
         full = cm.dot_neg ? (vpa_pkg::HALF_TURN - cz) : cz;
      end else if (!cm.dot_neg) begin
         full = cm.cross_neg ? (TB'(0) - cz) : cz;
      end else begin
         full = cm.cross_neg ? (vpa_pkg::HALF_TURN + cz) : (vpa_pkg::HALF_TURN - cz);
      end
      full_rnd = full + vpa_pkg::ROUND_ADD;
      pipe_rsp.degenerate = cm.degenerate;
      pipe_rsp.angle      = cm.degenerate ? '0 : full_rnd[TB-1 -: AB];
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_valid_ff && rsp_stall) begin
         if (advance && cv) begin
            skid_valid_in = 1'b1;
            skid_data_in  = pipe_rsp;
         end
      end else if (skid_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end else begin
         rsp_valid_in = cv;
         rsp_data_in  = pipe_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule
